[hw/rtl/rakh_pkg.sv]
package rakh_pkg;

	localparam int HASH_W  = 32;
	localparam int BCNT_W  = 31;
	localparam int BYTE_W  = 8;
	localparam int ROT_L   = 5;
	localparam int Q_DEPTH = 4;
	localparam int STEP_W  = $clog2(HASH_W);

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// rotate left, then add the byte sign-extended
	function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
		input logic [BYTE_W-1:0] b);
		return {h[HASH_W-ROT_L-1:0], h[HASH_W-1:HASH_W-ROT_L]}
			+ {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
	endfunction

endpackage

[hw/rtl/rotate_add_key_hash_bucket.sv]
// Key bytes are taken at one per cycle while full is low; the hash updates in the same cycle.
// A key's result passes in order through the hash queue, the bit-serial remainder unit and
// the output register, and any of them can hold it while a later one is busy.
// The remainder unit takes a new key only when idle; a 4-deep hash queue absorbs short keys.
// arst_n clears the running hash, queue pointers and output valid; bucket_count resets to 1.
module rotate_add_key_hash_bucket #(
	parameter int Q_DEPTH = rakh_pkg::Q_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [rakh_pkg::BYTE_W-1:0]   key_byte,
	input  logic                          last_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [rakh_pkg::HASH_W-1:0] key_hash,
	output logic [rakh_pkg::BCNT_W-1:0]   bucket_index,
	input  logic                          cfg_wr_en,
	input  logic [rakh_pkg::BCNT_W-1:0]   cfg_wr_data
);
	import rakh_pkg::*;

	q_status_t         q_stat;
	logic              q_push;
	logic              q_pop;
	logic [HASH_W-1:0] q_wr_data;
	logic [HASH_W-1:0] q_rd_data;

	rakh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.key_byte  (key_byte),
		.last_byte (last_byte),
		.q_stat    (q_stat),
		.full      (full),
		.q_push    (q_push),
		.q_data    (q_wr_data)
	);

	rakh_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.q_stat  (q_stat)
	);

	rakh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.q_stat       (q_stat),
		.q_data       (q_rd_data),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.key_hash     (key_hash),
		.bucket_index (bucket_index)
	);

endmodule

[hw/rtl/rakh_front.sv]
module rakh_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [rakh_pkg::BYTE_W-1:0]   key_byte,
	input  logic                          last_byte,
	input  rakh_pkg::q_status_t           q_stat,
	output logic                          full,
	output logic                          q_push,
	output logic [rakh_pkg::HASH_W-1:0]   q_data
);
	import rakh_pkg::*;

	logic [HASH_W-1:0] running_hash_q;
	logic [HASH_W-1:0] hash_next;
	logic              accept;

	assign full      = q_stat.full;
	assign accept    = push && !q_stat.full;
	assign hash_next = hash_step(running_hash_q, key_byte);
	assign q_push    = accept && last_byte;
	assign q_data    = hash_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= '0;
		end else if (accept) begin
			running_hash_q <= last_byte ? '0 : hash_next;
		end
	end

endmodule

[hw/rtl/rakh_fifo.sv]
module rakh_fifo #(
	parameter int DEPTH = rakh_pkg::Q_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rakh_pkg::HASH_W-1:0]   wr_data,
	input  logic                          rd_en,
	output logic [rakh_pkg::HASH_W-1:0]   rd_data,
	output rakh_pkg::q_status_t           q_stat
);
	import rakh_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [HASH_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_wr        = wr_en && !q_stat.full;
	assign do_rd        = rd_en && !q_stat.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/rakh_back.sv]
module rakh_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rakh_pkg::BCNT_W-1:0]   cfg_wr_data,
	input  rakh_pkg::q_status_t           q_stat,
	input  logic [rakh_pkg::HASH_W-1:0]   q_data,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [rakh_pkg::HASH_W-1:0] key_hash,
	output logic [rakh_pkg::BCNT_W-1:0]   bucket_index
);
	import rakh_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [BCNT_W-1:0] bucket_count_q;
	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] dvd_q;
	logic [BCNT_W-1:0] dvs_q;
	logic [BCNT_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [HASH_W-1:0] out_hash_q;
	logic [BCNT_W-1:0] out_bucket_q;

	logic [HASH_W-1:0] mag;
	logic [HASH_W-1:0] trial;
	logic [HASH_W-1:0] diff;
	logic              fits;
	logic              out_free;
	logic              out_load;

	assign mag      = q_data[HASH_W-1] ? (HASH_W'(0) - q_data) : q_data;
	assign trial    = {rem_q, dvd_q[HASH_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign fits     = (trial >= {1'b0, dvs_q});
	assign out_free = !out_valid_q || pop;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign q_pop    = (state_q == ST_IDLE) && !q_stat.empty;

	assign empty        = !out_valid_q;
	assign key_hash     = out_hash_q;
	assign bucket_index = out_bucket_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BCNT_W'(1);
		end else if (cfg_wr_en) begin
			bucket_count_q <= cfg_wr_data;
		end
	end

	// restoring remainder, one dividend bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(HASH_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hash_q <= q_data;
			dvd_q  <= mag;
			dvs_q  <= bucket_count_q;
			rem_q  <= '0;
		end else if (state_q == ST_RUN) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= fits ? diff[BCNT_W-1:0] : trial[BCNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hash_q   <= hash_q;
			out_bucket_q <= (dvs_q == '0) ? '0 : rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/rakh_checker.sv]
module rakh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic signed [rakh_pkg::HASH_W-1:0] key_hash,
	input logic [rakh_pkg::BCNT_W-1:0]   bucket_index,
	input logic                          cfg_wr_en,
	input logic [rakh_pkg::BCNT_W-1:0]   cfg_wr_data
);
	import rakh_pkg::*;

	logic [BCNT_W-1:0] bcnt_q;
	logic [HASH_W-1:0] hash_mag;

	assign hash_mag = key_hash[HASH_W-1] ? (HASH_W'(0) - key_hash) : key_hash;

	// shadow of the bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= BCNT_W'(1);
		end else if (cfg_wr_en) begin
			bcnt_q <= cfg_wr_data;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(key_hash) && $stable(bucket_index))
		else $error("result changed while waiting");

	a_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && bcnt_q != '0 |-> bucket_index < bcnt_q)
		else $error("bucket index not below bucket count");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && bcnt_q == '0 |-> bucket_index == '0)
		else $error("bucket index nonzero with zero bucket count");

	a_below_mag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> {1'b0, bucket_index} <= hash_mag)
		else $error("bucket index exceeds hash magnitude");

endmodule

bind rotate_add_key_hash_bucket rakh_checker u_rakh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.key_hash     (key_hash),
	.bucket_index (bucket_index),
	.cfg_wr_en    (cfg_wr_en),
	.cfg_wr_data  (cfg_wr_data)
);

[dv/rotate_add_key_hash_bucket_tb.sv]
`timescale 1ns / 100ps

module rotate_add_key_hash_bucket_tb;

	import rakh_pkg::*;

	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_BYTES    = 100;

	typedef struct {
		logic signed [HASH_W-1:0] hash;
		logic [BCNT_W-1:0]        bucket;
	} key_result_t;

	logic                     clk;
	logic                     arst_n       = 1'b0;
	logic                     push         = 1'b0;
	logic                     full;
	logic [BYTE_W-1:0]        key_byte     = '0;
	logic                     last_byte    = 1'b0;
	logic                     empty;
	logic                     pop          = 1'b0;
	logic signed [HASH_W-1:0] key_hash;
	logic [BCNT_W-1:0]        bucket_index;
	logic                     cfg_wr_en    = 1'b0;
	logic [BCNT_W-1:0]        cfg_wr_data  = '0;

	// predictor state
	logic [HASH_W-1:0] hash_acc;
	logic [BCNT_W-1:0] bucket_count_q;
	key_result_t       key_result_q[$];

	int unsigned send_idle_pct = 17;
	int unsigned recv_idle_pct = 77;
	int unsigned error_count     = 0;
	int unsigned bytes_sent      = 0;
	int unsigned keys_sent       = 0;
	int unsigned results_checked = 0;
	int unsigned cfg_writes      = 0;

	rotate_add_key_hash_bucket uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.key_byte     (key_byte),
		.last_byte    (last_byte),
		.empty        (empty),
		.pop          (pop),
		.key_hash     (key_hash),
		.bucket_index (bucket_index),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [HASH_W-1:0] rotate_add(input logic [HASH_W-1:0] h,
		input logic [BYTE_W-1:0] b);
		logic [HASH_W-1:0] rot;
		rot = {h[HASH_W-6:0], h[HASH_W-1:HASH_W-5]};
		return rot + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
	endfunction

	function automatic logic [BCNT_W-1:0] bucket_for(input logic [HASH_W-1:0] h,
		input logic [BCNT_W-1:0] count);
		logic [HASH_W-1:0] mag;
		logic [HASH_W-1:0] rem;
		if (count == '0)
			return '0;
		// two's complement negate; the most negative hash stays 2^31 as unsigned
		mag = h[HASH_W-1] ? (~h + 1'b1) : h;
		rem = mag % {1'b0, count};
		return rem[BCNT_W-1:0];
	endfunction

	function automatic logic [BYTE_W-1:0] random_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'h7f;
			2: return 8'h80;
			3: return 8'hff;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	// one byte transaction; push stays high on return so back-to-back bytes need no toggle
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
		key_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push      <= 1'b1;
		key_byte  <= b;
		last_byte <= lst;
		@(posedge clk);
		while (full)
			@(posedge clk);
		hash_acc = rotate_add(hash_acc, b);
		bytes_sent++;
		if (lst) begin
			r.hash   = hash_acc;
			r.bucket = bucket_for(hash_acc, bucket_count_q);
			key_result_q.insert(key_result_q.size(), r);
			hash_acc = '0;
			keys_sent++;
		end
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (key_result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_bucket_count(input logic [BCNT_W-1:0] count);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		bucket_count_q = count;
		cfg_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_key_random(output int unsigned len);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70)
			len = $urandom_range(1, 4);
		else if (pick < 95)
			len = $urandom_range(5, 12);
		else
			len = $urandom_range(13, 40);
		for (int unsigned i = 0; i < len; i++)
			send_byte(random_byte(), i == len - 1);
	endtask

	// bucket count still at its reset value of one: every bucket is zero
	task automatic test_reset_count();
		send_byte(8'h5a, 1'b1);
		send_byte(8'hc3, 1'b1);
	endtask

	task automatic test_directed_keys();
		set_bucket_count(31'd7);
		// single-byte keys hash to the sign-extended byte
		send_byte(8'h00, 1'b1);
		send_byte(8'h7f, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b1);
	endtask

	// 0x02 then six zero bytes rotates to exactly 0x80000000
	task automatic test_most_negative();
		set_bucket_count(31'd3);
		send_byte(8'h02, 1'b0);
		for (int i = 0; i < 6; i++)
			send_byte(8'h00, i == 5);
	endtask

	task automatic test_zero_count();
		set_bucket_count('0);
		send_byte(8'h80, 1'b1);
		send_byte(8'h31, 1'b0);
		send_byte(8'hfe, 1'b1);
	endtask

	task automatic test_random_traffic();
		logic [BCNT_W-1:0] plan[12];
		int unsigned sent;
		int unsigned len;
		plan = '{31'h7fffffff, 31'd1, 31'd3, 31'd0, 31'd2, 31'd10, 31'h40000000, 31'd0,
			31'd0, 31'd65521, 31'd0, 31'h7fffffff};
		plan[3]  = BCNT_W'($urandom());
		plan[7]  = BCNT_W'($urandom_range(1, 1000));
		plan[10] = BCNT_W'($urandom());
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 17; recv_idle_pct = 77; end
				1: begin send_idle_pct = 77; recv_idle_pct = 17; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int ph = 0; ph < 4; ph++) begin
				set_bucket_count(plan[mode * 4 + ph]);
				sent = 0;
				while (sent < PHASE_BYTES) begin
					send_key_random(len);
					sent += len;
				end
			end
		end
	endtask

	// result checker and receiver stall
	initial begin
		key_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (key_result_q.size() == 0) begin
					error_count++;
					$error("unexpected result: key_hash %0d bucket_index %0d",
						key_hash, bucket_index);
				end else begin
					exp_r = key_result_q.pop_front();
					results_checked++;
					if (key_hash !== exp_r.hash) begin
						error_count++;
						$error("key_hash: expected %0d, actual %0d", exp_r.hash, key_hash);
					end
					if (bucket_index !== exp_r.bucket) begin
						error_count++;
						$error("bucket_index: expected %0d, actual %0d",
							exp_r.bucket, bucket_index);
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ends the run if no transaction happens for too long
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("rotate_add_key_hash_bucket verification failed");
		$finish;
	end

	initial begin
		hash_acc       = '0;
		bucket_count_q = 31'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_count();
		test_directed_keys();
		test_most_negative();
		test_zero_count();
		test_random_traffic();
		drain_results();

		$display("covered %0d keys in %0d bytes, %0d results checked", keys_sent, bytes_sent,
			results_checked);
		$display("over %0d bucket-count writes and three sender/receiver stall patterns",
			cfg_writes);
		if (error_count == 0)
			$display("rotate_add_key_hash_bucket verification clean");
		else
			$display("rotate_add_key_hash_bucket verification failed");
		$finish;
	end

endmodule
